// ===== hw/rtl/ssaa_pkg.sv =====
// Shared types and constants for the supersampled circle coverage blend.
// Used by every module under hw/rtl; depends on nothing.
`default_nettype none

package ssaa_pkg;

    localparam int unsigned FIELD_XY_W = 12;
    localparam int unsigned COLOR_W    = 24;
    localparam int unsigned LIMIT_W    = 26;  // 16 * radius^2 with an 11-bit radius
    localparam int unsigned APB_AW     = 4;

    // Register indexes (byte address bits 3:2)
    localparam logic [1:0] REG_CENTER_X   = 2'd0;
    localparam logic [1:0] REG_CENTER_Y   = 2'd1;
    localparam logic [1:0] REG_RADIUS     = 2'd2;
    localparam logic [1:0] REG_DRAW_COLOR = 2'd3;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [2:0] FULL_SAMPLES = 3'd4;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [31:0] background_color;
    } pixel_t;

    typedef struct packed {
        logic        write_pixel;
        logic [11:0] out_x;
        logic [11:0] out_y;
        logic [31:0] blended_color;
        logic [2:0]  covered_samples;
    } result_t;

    typedef struct packed {
        logic [11:0] center_x;
        logic [11:0] center_y;
        logic [10:0] radius;
        logic [23:0] draw_color;
    } cfg_t;

    // Covered-sample stage output handed to the blend stage
    typedef struct packed {
        logic        valid;
        logic [2:0]  count;
        logic [11:0] x;
        logic [11:0] y;
        logic [23:0] bg;
    } cover_t;

    // Coverage is count/4, so the per-mille blend reduces to a shift by two.
    function automatic logic [7:0] blend_ch(input logic [7:0] fg, input logic [7:0] bg,
                                            input logic [2:0] count);
        logic [2:0]  inv;
        logic [9:0]  sum;
        inv = FULL_SAMPLES - count;
        sum = 10'(fg * count) + 10'(bg * inv);
        return sum[9:2];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ssaa_cfg.sv =====
// APB register file: circle center, radius and draw color.
// Depends on ssaa_pkg.
`default_nettype none

module ssaa_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ssaa_pkg::APB_AW-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    output ssaa_pkg::cfg_t                     cfg
);

    ssaa_pkg::cfg_t cfg_reg;
    ssaa_pkg::cfg_t cfg_next;
    logic [1:0]     idx;
    logic           wr_en;

    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                ssaa_pkg::REG_CENTER_X:   cfg_next.center_x   = pwdata[11:0];
                ssaa_pkg::REG_CENTER_Y:   cfg_next.center_y   = pwdata[11:0];
                ssaa_pkg::REG_RADIUS:     cfg_next.radius     = pwdata[10:0];
                ssaa_pkg::REG_DRAW_COLOR: cfg_next.draw_color = pwdata[23:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            ssaa_pkg::REG_CENTER_X:   prdata = 32'(cfg_reg.center_x);
            ssaa_pkg::REG_CENTER_Y:   prdata = 32'(cfg_reg.center_y);
            ssaa_pkg::REG_RADIUS:     prdata = 32'(cfg_reg.radius);
            ssaa_pkg::REG_DRAW_COLOR: prdata = 32'(cfg_reg.draw_color);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ssaa_cover.sv =====
// Sample coverage pipeline: offsets, squares, compare and count (three stages).
// Depends on ssaa_pkg.
`default_nettype none

module ssaa_cover #(
    parameter int unsigned COORD_BITS = 12
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  ssaa_pkg::pixel_t     pixel,
    input  ssaa_pkg::cfg_t       cfg,
    output ssaa_pkg::cover_t     samples
);

    localparam int unsigned WB = (COORD_BITS > ssaa_pkg::FIELD_XY_W) ?
                                 COORD_BITS : ssaa_pkg::FIELD_XY_W;
    localparam int unsigned DW = COORD_BITS + 3;        // signed 4u+3
    localparam int unsigned SW = 2 * (COORD_BITS + 2);  // square magnitude
    localparam int unsigned NW = SW + 1;
    localparam int unsigned CW = (NW > ssaa_pkg::LIMIT_W) ? NW : ssaa_pkg::LIMIT_W;

    // ---- stage 1: masked coordinates and sample offsets (units of 1/4 pixel)
    logic [WB-1:0]           px_w, py_w, cx_w, cy_w, pxm_w, pym_w;
    logic [COORD_BITS-1:0]   px, py, cx, cy;
    logic signed [COORD_BITS:0] du, dv;
    logic signed [DW-1:0]    du4, dv4;
    logic signed [DW-1:0]    ax_next, bx_next, ay_next, by_next;
    logic signed [DW-1:0]    ax_reg, bx_reg, ay_reg, by_reg;
    logic                    v1_reg;
    logic [11:0]             x1_reg, y1_reg;
    logic [23:0]             bg1_reg;

    assign px_w  = WB'(pixel.pixel_x);
    assign py_w  = WB'(pixel.pixel_y);
    assign cx_w  = WB'(cfg.center_x);
    assign cy_w  = WB'(cfg.center_y);
    assign px    = px_w[COORD_BITS-1:0];
    assign py    = py_w[COORD_BITS-1:0];
    assign cx    = cx_w[COORD_BITS-1:0];
    assign cy    = cy_w[COORD_BITS-1:0];
    assign pxm_w = WB'(px);
    assign pym_w = WB'(py);

    assign du      = $signed({1'b0, px}) - $signed({1'b0, cx});
    assign dv      = $signed({1'b0, py}) - $signed({1'b0, cy});
    assign du4     = DW'(du) <<< 2;
    assign dv4     = DW'(dv) <<< 2;
    assign ax_next = du4 + DW'(1);
    assign bx_next = du4 + DW'(3);
    assign ay_next = dv4 + DW'(1);
    assign by_next = dv4 + DW'(3);

    always_ff @(posedge clk)
    begin
        ax_reg  <= ax_next;
        bx_reg  <= bx_next;
        ay_reg  <= ay_next;
        by_reg  <= by_next;
        x1_reg  <= pxm_w[11:0];
        y1_reg  <= pym_w[11:0];
        bg1_reg <= pixel.background_color[23:0];
    end

    // Inside test: (4u+a)^2 + (4v+b)^2 <= 16 r^2, exact after dividing out 250^2.
    logic [ssaa_pkg::LIMIT_W-1:0] lim_next, lim_reg;
    logic [21:0]                  r_sq;

    assign r_sq     = 22'(cfg.radius) * 22'(cfg.radius);
    assign lim_next = {r_sq, 4'b0000};

    always_ff @(posedge clk)
    begin
        lim_reg <= lim_next;
    end

    // ---- stage 2: squares
    logic signed [2*DW-1:0] pax, pbx, pay, pby;
    logic [SW-1:0]          sax_reg, sbx_reg, say_reg, sby_reg;
    logic                   v2_reg;
    logic [11:0]            x2_reg, y2_reg;
    logic [23:0]            bg2_reg;

    assign pax = ax_reg * ax_reg;
    assign pbx = bx_reg * bx_reg;
    assign pay = ay_reg * ay_reg;
    assign pby = by_reg * by_reg;

    always_ff @(posedge clk)
    begin
        sax_reg <= SW'(pax);
        sbx_reg <= SW'(pbx);
        say_reg <= SW'(pay);
        sby_reg <= SW'(pby);
        x2_reg  <= x1_reg;
        y2_reg  <= y1_reg;
        bg2_reg <= bg1_reg;
    end

    // ---- stage 3: four distance compares and the count
    logic [CW-1:0] lim_w;
    logic [CW-1:0] d_aa, d_ba, d_ab, d_bb;
    logic [3:0]    hit;
    logic [2:0]    count_next;
    logic          v3_reg;
    logic [2:0]    count3_reg;
    logic [11:0]   x3_reg, y3_reg;
    logic [23:0]   bg3_reg;

    assign lim_w = CW'(lim_reg);
    assign d_aa  = CW'(sax_reg) + CW'(say_reg);
    assign d_ba  = CW'(sbx_reg) + CW'(say_reg);
    assign d_ab  = CW'(sax_reg) + CW'(sby_reg);
    assign d_bb  = CW'(sbx_reg) + CW'(sby_reg);
    assign hit   = {d_bb <= lim_w, d_ab <= lim_w, d_ba <= lim_w, d_aa <= lim_w};
    assign count_next = 3'(hit[0]) + 3'(hit[1]) + 3'(hit[2]) + 3'(hit[3]);

    always_ff @(posedge clk)
    begin
        count3_reg <= count_next;
        x3_reg     <= x2_reg;
        y3_reg     <= y2_reg;
        bg3_reg    <= bg2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign samples = '{valid: v3_reg, count: count3_reg, x: x3_reg, y: y3_reg, bg: bg3_reg};

endmodule

`default_nettype wire

// ===== hw/rtl/ssaa_blend.sv =====
// Final stage: per-channel color blend and result register.
// Depends on ssaa_pkg.
`default_nettype none

module ssaa_blend (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  ssaa_pkg::cover_t    samples,
    input  wire logic [23:0]    draw_color,
    output logic                done,
    output ssaa_pkg::result_t   result
);

    ssaa_pkg::result_t result_next, result_reg;
    logic              done_reg;
    logic [7:0]        red, green, blue;

    assign red   = ssaa_pkg::blend_ch(draw_color[23:16], samples.bg[23:16], samples.count);
    assign green = ssaa_pkg::blend_ch(draw_color[15:8],  samples.bg[15:8],  samples.count);
    assign blue  = ssaa_pkg::blend_ch(draw_color[7:0],   samples.bg[7:0],   samples.count);

    always_comb
    begin
        result_next.out_x           = samples.x;
        result_next.out_y           = samples.y;
        result_next.covered_samples = samples.count;
        result_next.write_pixel     = (samples.count != 3'd0);
        // no coverage: nothing to write, color word forced to zero
        if (samples.count != 3'd0)
            result_next.blended_color = {ssaa_pkg::ALPHA_OPAQUE, red, green, blue};
        else
            result_next.blended_color = '0;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= samples.valid;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ssaa_circle_coverage_blend.sv =====
// Top level of the 4x ordered-grid antialiased circle shader.
// Depends on ssaa_pkg, ssaa_cfg, ssaa_cover and ssaa_blend.
//
// Usage:
//   Pixel channel: drive pixel and pulse start; a transfer happens at each edge
//   with start high and busy low. busy is never raised, so one pixel can be
//   taken every clock.
//   Result channel: done is high for one cycle with result holding the shaded
//   pixel, in input order, once the pixel has passed the pipeline stages below.
//   The receiver must take it in that cycle; there is no back pressure.
//   Pipeline: stage 1 sample offsets, stage 2 the four squaring multipliers,
//   stage 3 the distance compares and count, stage 4 the blend and output
//   register. Throughput is one pixel per cycle.
//   Config: APB registers at byte addresses 0 (center_x), 4 (center_y),
//   8 (radius), 12 (draw_color). Write them only while no pixel is in flight.
//   Reset: rst_n clears the config registers to 0 and the pipeline valid bits;
//   no result is issued until a pixel is transferred after reset.
`default_nettype none

module ssaa_circle_coverage_blend #(
    parameter int unsigned COORD_BITS = 12
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  ssaa_pkg::pixel_t                 pixel,
    output logic                             done,
    output ssaa_pkg::result_t                result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ssaa_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);

    ssaa_pkg::cfg_t   cfg;
    ssaa_pkg::cover_t samples;
    logic             in_xfer;

    assign busy    = 1'b0;
    assign in_xfer = start && !busy;

    ssaa_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssaa_cover #(
        .COORD_BITS (COORD_BITS)
    ) u_cover (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_xfer),
        .pixel    (pixel),
        .cfg      (cfg),
        .samples  (samples)
    );

    ssaa_blend u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .draw_color (cfg.draw_color),
        .done       (done),
        .result     (result)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> ##4 done)
        else $error("pixel transfer without result four cycles later");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.covered_samples <= ssaa_pkg::FULL_SAMPLES))
        else $error("covered sample count out of range");

    a_write_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.write_pixel == (result.covered_samples != 3'd0)))
        else $error("write flag disagrees with coverage");

    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.write_pixel) |->
            (result.blended_color[31:24] == ssaa_pkg::ALPHA_OPAQUE))
        else $error("written pixel is not opaque");

endmodule

`default_nettype wire

// ===== test/tb_ssaa_circle_coverage_blend.sv =====
// Self-checking testbench for ssaa_circle_coverage_blend: drives pixels and APB
// register writes, predicts each shaded pixel and checks every result transfer.
// Depends on ssaa_pkg and the ssaa_circle_coverage_blend RTL.
`default_nettype none

module tb_ssaa_circle_coverage_blend;

    localparam int IDLE_LIMIT   = 1000;  // cycles with no transfer of any kind
    localparam int PHASES       = 8;
    localparam int PHASE_PIXELS = 241;
    localparam int DRAIN_CYCLES = 8;

    // Holds the circle registers and the shaded pixels still owed by the block.
    class shade_scoreboard;
        logic [11:0]       center_x;
        logic [11:0]       center_y;
        logic [10:0]       radius;
        logic [23:0]       draw_color;
        ssaa_pkg::result_t owed[$];
        int                errors;

        function new();
            center_x   = '0;
            center_y   = '0;
            radius     = '0;
            draw_color = '0;
            errors     = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                ssaa_pkg::REG_CENTER_X:   center_x   = value[11:0];
                ssaa_pkg::REG_CENTER_Y:   center_y   = value[11:0];
                ssaa_pkg::REG_RADIUS:     radius     = value[10:0];
                ssaa_pkg::REG_DRAW_COLOR: draw_color = value[23:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return owed.size();
        endfunction

        task report(string msg);
            $display("[%0t] ERROR %s", $time, msg);
            errors++;
        endtask

        function logic [7:0] mix(logic [7:0] fg, logic [7:0] bg, int cov);
            int acc;
            acc = (int'(fg) * cov + int'(bg) * (1000 - cov)) / 1000;
            return acc[7:0];
        endfunction

        // Sample grid in thousandths of a pixel, compared against r^2 * 1e6.
        function ssaa_pkg::result_t shade(ssaa_pkg::pixel_t p);
            longint            dx, dy, ax, bx, ay, by, lim;
            int                n;
            int                cov;
            ssaa_pkg::result_t r;
            dx  = (longint'(p.pixel_x) - longint'(center_x)) * 1000;
            dy  = (longint'(p.pixel_y) - longint'(center_y)) * 1000;
            ax  = dx + 250;
            bx  = dx + 750;
            ay  = dy + 250;
            by  = dy + 750;
            lim = longint'(radius) * longint'(radius) * 1000000;
            n   = 0;
            if (ax * ax + ay * ay <= lim) n++;
            if (bx * bx + ay * ay <= lim) n++;
            if (ax * ax + by * by <= lim) n++;
            if (bx * bx + by * by <= lim) n++;
            r                 = '0;
            r.write_pixel     = (n != 0);
            r.out_x           = p.pixel_x;
            r.out_y           = p.pixel_y;
            r.covered_samples = 3'(n);
            if (n != 0)
            begin
                cov = n * 250;
                r.blended_color = {ssaa_pkg::ALPHA_OPAQUE,
                                   mix(draw_color[23:16], p.background_color[23:16], cov),
                                   mix(draw_color[15:8], p.background_color[15:8], cov),
                                   mix(draw_color[7:0], p.background_color[7:0], cov)};
            end
            return r;
        endfunction

        function void note_pixel(ssaa_pkg::pixel_t p);
            owed.push_back(shade(p));
        endfunction

        task check_result(ssaa_pkg::result_t got);
            ssaa_pkg::result_t want;
            if (owed.size() == 0)
            begin
                report($sformatf("result with no pixel pending (x=%0d y=%0d)",
                                 got.out_x, got.out_y));
            end
            else
            begin
                want = owed.pop_front();
                if (got.write_pixel !== want.write_pixel)
                    report($sformatf("x=%0d y=%0d write_pixel got %0b want %0b",
                                     want.out_x, want.out_y, got.write_pixel,
                                     want.write_pixel));
                if (got.out_x !== want.out_x)
                    report($sformatf("out_x got %0d want %0d", got.out_x, want.out_x));
                if (got.out_y !== want.out_y)
                    report($sformatf("out_y got %0d want %0d", got.out_y, want.out_y));
                if (got.blended_color !== want.blended_color)
                    report($sformatf("x=%0d y=%0d blended_color got %08h want %08h",
                                     want.out_x, want.out_y, got.blended_color,
                                     want.blended_color));
                if (got.covered_samples !== want.covered_samples)
                    report($sformatf("x=%0d y=%0d covered_samples got %0d want %0d",
                                     want.out_x, want.out_y, got.covered_samples,
                                     want.covered_samples));
            end
        endtask
    endclass

    logic                        clk     = 1'b0;
    logic                        rst_n   = 1'b0;
    logic                        start   = 1'b0;
    logic                        busy;
    ssaa_pkg::pixel_t            pixel   = '0;
    logic                        done;
    ssaa_pkg::result_t           result;
    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [ssaa_pkg::APB_AW-1:0] paddr   = '0;
    logic [31:0]                 pwdata  = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    shade_scoreboard             sb;
    int                          idle_cycles = 0;

    ssaa_circle_coverage_blend dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .pixel   (pixel),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Transfer monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_pixel(pixel);
            if (done)
                sb.check_result(result);
            if ((start && !busy) || done || (psel && penable && pready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("ssaa_circle_coverage_blend: mismatch");
                $finish;
            end
        end
    end

    task apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.set_register(idx, value);
    endtask

    // Upper bits beyond each register's width are filled with junk.
    task configure(input int cx, input int cy, input int r, input logic [23:0] color);
        apb_write(ssaa_pkg::REG_CENTER_X, 32'(cx) | ($urandom() & 32'hFFFF_F000));
        apb_write(ssaa_pkg::REG_CENTER_Y, 32'(cy) | ($urandom() & 32'hFFFF_F000));
        apb_write(ssaa_pkg::REG_RADIUS, 32'(r) | ($urandom() & 32'hFFFF_F800));
        apb_write(ssaa_pkg::REG_DRAW_COLOR, {8'($urandom_range(0, 255)), color});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task send_pixel(input int x, input int y, input logic [31:0] bg, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        pixel <= '{pixel_x: 12'(x), pixel_y: 12'(y), background_color: bg};
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task drain();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    function int clamp_coord(int v);
        if (v < 0) return 0;
        if (v > 4095) return 4095;
        return v;
    endfunction

    initial
    begin
        int cx, cy, r, dx, dy, x, y, gap, pick;
        bit gapped;
        logic [23:0] color;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: zero radius, nothing is covered
        send_pixel(0, 0, 32'hFFFF_FFFF, 0);
        send_pixel(4095, 4095, 32'h0000_0000, 0);
        drain();

        // Small circle: full, partial and empty pixels around the rim
        configure(100, 100, 3, 24'hFF8001);
        send_pixel(100, 100, 32'h0000_0000, 0);
        send_pixel(102, 101, 32'hFFFF_FFFF, 0);
        send_pixel(103, 100, 32'h00FF_FFFF, 1);
        send_pixel(97, 100, 32'hFF00_0000, 0);
        send_pixel(96, 100, 32'h1234_5678, 0);
        send_pixel(102, 102, 32'hFFFF_FFFF, 2);
        for (int i = 97; i <= 103; i++)
            send_pixel(i, 102, 32'h00A0_5FC3, 0);
        send_pixel(4095, 4095, 32'hFFFF_FFFF, 0);
        send_pixel(0, 4095, 32'h0000_0000, 0);
        send_pixel(4095, 0, 32'h0000_0000, 0);
        drain();

        // Largest radius from the origin corner
        configure(0, 0, 2047, 24'hFFFFFF);
        send_pixel(0, 0, 32'h0000_0000, 0);
        send_pixel(4095, 4095, 32'hFFFF_FFFF, 0);
        send_pixel(2046, 0, 32'h0000_0000, 0);
        send_pixel(1447, 1447, 32'h0000_0000, 0);
        send_pixel(1447, 1448, 32'h0000_0000, 0);
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            color = 24'($urandom());
            case (ph)
                0:
                begin
                    cx = 0;
                    cy = 0;
                    r = 2047;
                    color = 24'hFFFFFF;
                end
                1:
                begin
                    cx = 4095;
                    cy = 4095;
                    r = 2047;
                    color = 24'h000000;
                end
                2:
                begin
                    cx = $urandom_range(0, 4095);
                    cy = $urandom_range(0, 4095);
                    r = 0;
                end
                3:
                begin
                    cx = $urandom_range(0, 4095);
                    cy = $urandom_range(0, 4095);
                    r = $urandom_range(100, 400);
                end
                default:
                begin
                    cx = $urandom_range(0, 4095);
                    cy = $urandom_range(0, 4095);
                    r  = $urandom_range(1, 40);
                end
            endcase
            configure(cx, cy, r, color);
            gapped = (ph % 3 != 0);
            for (int i = 0; i < PHASE_PIXELS; i++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                begin
                    // near the rim, where partial coverage lives
                    dx = $urandom_range(0, 2 * r) - r;
                    dy = int'($sqrt(real'(r * r - dx * dx)));
                    if ($urandom_range(0, 1)) dy = -dy;
                    x = clamp_coord(cx + dx + $urandom_range(0, 4) - 2);
                    y = clamp_coord(cy + dy + $urandom_range(0, 4) - 2);
                end
                else if (pick < 8)
                begin
                    x = clamp_coord(cx + $urandom_range(0, 2 * r + 4) - r - 2);
                    y = clamp_coord(cy + $urandom_range(0, 2 * r + 4) - r - 2);
                end
                else
                begin
                    x = $urandom_range(0, 4095);
                    y = $urandom_range(0, 4095);
                end
                gap = (gapped && $urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
                send_pixel(x, y, $urandom(), gap);
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("ssaa_circle_coverage_blend: match");
        else
            $display("ssaa_circle_coverage_blend: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/ssaa_pkg.sv
hw/rtl/ssaa_cfg.sv
hw/rtl/ssaa_cover.sv
hw/rtl/ssaa_blend.sv
hw/rtl/ssaa_circle_coverage_blend.sv
test/tb_ssaa_circle_coverage_blend.sv
